// ===== design/vgpb_pkg.sv =====
// Shared types and constants for the voxel grid point binner.
package vgpb_pkg;

    localparam int COORD_W = 32;
    localparam int DIV_W   = 31;
    localparam int PNUM_W  = 20;
    localparam int IDX_W   = 9;
    localparam int CNT_W   = 11;
    localparam int REG_IDX_W = 3;
    localparam int GRID_CELLS = 512;
    localparam logic [CNT_W-1:0] COUNT_MAX = 11'd2047;

    // Configuration register indexes.
    localparam logic [REG_IDX_W-1:0] REG_MIN_X = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_MIN_Y = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_MIN_Z = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_DIV_X = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_DIV_Y = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_DIV_Z = 3'd5;

    // Classified point handed from the front part to the back part.
    typedef struct packed {
        logic [IDX_W-1:0]  cell_index;
        logic              clamped;
        logic [PNUM_W-1:0] point_number;
    } vgpb_item_t;

endpackage

// ===== design/vgpb_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module vgpb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end
endmodule

// ===== design/vgpb_front.sv =====
// Front part: bit-serial floor division per axis, clamping and voxel index forming.
module vgpb_front (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic signed [vgpb_pkg::COORD_W-1:0] coord_x,
    input  logic signed [vgpb_pkg::COORD_W-1:0] coord_y,
    input  logic signed [vgpb_pkg::COORD_W-1:0] coord_z,
    input  logic [vgpb_pkg::PNUM_W-1:0]      point_number,
    input  logic signed [vgpb_pkg::COORD_W-1:0] min_x,
    input  logic signed [vgpb_pkg::COORD_W-1:0] min_y,
    input  logic signed [vgpb_pkg::COORD_W-1:0] min_z,
    input  logic [vgpb_pkg::DIV_W-1:0]       div_x,
    input  logic [vgpb_pkg::DIV_W-1:0]       div_y,
    input  logic [vgpb_pkg::DIV_W-1:0]       div_z,
    output logic                             item_valid,
    input  logic                             item_ready,
    output vgpb_pkg::vgpb_item_t             item
);
    import vgpb_pkg::*;

    localparam int DIFF_W = COORD_W + 1;
    localparam int STEP_W = $clog2(DIFF_W + 1);

    typedef enum logic [1:0] {S_IDLE, S_DIV, S_OUT} state_t;

    state_t state_reg;
    logic [STEP_W-1:0] step_reg;
    logic [DIFF_W-1:0] mag_reg [3];   // dividend magnitude, shifted out MSB first
    logic [DIFF_W-1:0] rem_reg [3];
    logic [DIFF_W-1:0] quo_reg [3];
    logic [DIV_W-1:0]  dv_reg  [3];
    logic              neg_reg [3];
    logic [PNUM_W-1:0] pnum_reg;
    vgpb_item_t        item_reg;

    logic signed [DIFF_W-1:0] diff [3];
    logic [DIFF_W-1:0] rem_sh [3];
    logic [DIFF_W-1:0] rem_nx [3];
    logic              ge     [3];
    logic [2:0]        cell_sel [3];
    logic              clip   [3];

    always_comb
    begin
        diff[0] = DIFF_W'(coord_x) - DIFF_W'(min_x);
        diff[1] = DIFF_W'(coord_y) - DIFF_W'(min_y);
        diff[2] = DIFF_W'(coord_z) - DIFF_W'(min_z);
        for (int a = 0; a < 3; a++)
        begin
            rem_sh[a] = {rem_reg[a][DIFF_W-2:0], mag_reg[a][DIFF_W-1]};
            ge[a]     = rem_sh[a] >= DIFF_W'(dv_reg[a]);
            rem_nx[a] = ge[a] ? rem_sh[a] - DIFF_W'(dv_reg[a]) : rem_sh[a];
            // Final quotient: a negative dividend clamps to cell 0, a quotient above 7 clamps to cell 7.
            if (neg_reg[a])
            begin
                clip[a] = (quo_reg[a] != '0) || (rem_reg[a] != '0);
                cell_sel[a] = 3'd0;
            end
            else if (quo_reg[a] > DIFF_W'(7))
            begin
                clip[a] = 1'b1;
                cell_sel[a] = 3'd7;
            end
            else
            begin
                clip[a] = 1'b0;
                cell_sel[a] = quo_reg[a][2:0];
            end
        end
    end

    assign in_ready   = (state_reg == S_IDLE);
    assign item_valid = (state_reg == S_OUT);
    assign item       = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg <= S_DIV;
                        step_reg  <= '0;
                    end
                end
                S_DIV:
                begin
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == STEP_W'(DIFF_W))
                    begin
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (item_ready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid)
        begin
            pnum_reg <= point_number;
            dv_reg[0] <= (div_x == '0) ? DIV_W'(1) : div_x;
            dv_reg[1] <= (div_y == '0) ? DIV_W'(1) : div_y;
            dv_reg[2] <= (div_z == '0) ? DIV_W'(1) : div_z;
            for (int a = 0; a < 3; a++)
            begin
                neg_reg[a] <= diff[a][DIFF_W-1];
                mag_reg[a] <= diff[a][DIFF_W-1] ? DIFF_W'(-diff[a]) : DIFF_W'(diff[a]);
                rem_reg[a] <= '0;
                quo_reg[a] <= '0;
            end
        end
        else if (state_reg == S_DIV && step_reg != STEP_W'(DIFF_W))
        begin
            for (int a = 0; a < 3; a++)
            begin
                rem_reg[a] <= rem_nx[a];
                quo_reg[a] <= {quo_reg[a][DIFF_W-2:0], ge[a]};
                mag_reg[a] <= {mag_reg[a][DIFF_W-2:0], 1'b0};
            end
        end
        else if (state_reg == S_DIV)
        begin
            item_reg.cell_index   <= {cell_sel[2], cell_sel[1], cell_sel[0]};
            item_reg.clamped      <= clip[0] | clip[1] | clip[2];
            item_reg.point_number <= pnum_reg;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV && step_reg == STEP_W'(DIFF_W)) |=> item_valid)
        else $error("front: division did not finish into output");
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid |-> !in_ready)
        else $error("front: accepting while holding a result");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> step_reg <= STEP_W'(DIFF_W))
        else $error("front: step counter overran");
endmodule

// ===== design/vgpb_queue.sv =====
// Two-entry queue between the front and back parts.
module vgpb_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_valid,
    output logic                 wr_ready,
    input  vgpb_pkg::vgpb_item_t wr_item,
    output logic                 rd_valid,
    input  logic                 rd_ready,
    output vgpb_pkg::vgpb_item_t rd_item
);
    import vgpb_pkg::*;

    vgpb_item_t slot_reg [2];
    logic       wptr_reg;
    logic       rptr_reg;
    logic [1:0] cnt_reg;
    logic       push;
    logic       pop;

    assign wr_ready = (cnt_reg != 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_item  = slot_reg[rptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= ~wptr_reg;
            end
            if (pop)
            begin
                rptr_reg <= ~rptr_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wptr_reg] <= wr_item;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) cnt_reg <= 2'd2)
        else $error("queue: count out of range");
    assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> cnt_reg == $past(cnt_reg) + 2'd1)
        else $error("queue: push lost");
    assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd0) |-> (rptr_reg == wptr_reg))
        else $error("queue: pointers out of step when empty");
endmodule

// ===== design/vgpb_back.sv =====
// Back part: counter read-modify-write, list append and result register.
module vgpb_back #(
    parameter int CELL_CAPACITY = 1024
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         item_valid,
    output logic                         item_ready,
    input  vgpb_pkg::vgpb_item_t         item,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [vgpb_pkg::IDX_W-1:0]   cell_index,
    output logic [vgpb_pkg::CNT_W-1:0]   slot,
    output logic                         stored,
    output logic                         overflow,
    output logic                         clamped,
    output logic                         clearing
);
    import vgpb_pkg::*;

    localparam int SLOT_W = (CELL_CAPACITY > 1) ? $clog2(CELL_CAPACITY) : 1;
    localparam int LIST_DEPTH = GRID_CELLS * CELL_CAPACITY;
    localparam int LIST_AW = $clog2(LIST_DEPTH);
    localparam logic [CNT_W:0] CAP = (CNT_W+1)'(CELL_CAPACITY);

    // S_CLEAR sweeps the counter RAM after reset; S_READ waits for the read data.
    typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_READ, S_OUT} state_t;

    state_t            state_reg;
    logic [IDX_W-1:0]  clr_reg;
    vgpb_item_t        cur_reg;
    logic [IDX_W-1:0]  idx_out_reg;
    logic [CNT_W-1:0]  slot_reg;
    logic              stored_reg;
    logic              ovf_reg;
    logic              clamp_reg;

    logic              cnt_we;
    logic [IDX_W-1:0]  cnt_waddr;
    logic [CNT_W-1:0]  cnt_wdata;
    logic [CNT_W-1:0]  cnt_rdata;
    logic [CNT_W-1:0]  cnt_now;
    logic              keep;
    logic              take;
    logic [LIST_AW-1:0] list_addr;

    assign take       = (state_reg == S_IDLE) && item_valid;
    assign item_ready = (state_reg == S_IDLE);
    assign cnt_now    = (cnt_rdata < COUNT_MAX) ? cnt_rdata + 1'b1 : COUNT_MAX;
    assign keep       = {1'b0, cnt_rdata} < CAP;
    assign list_addr  = LIST_AW'(cur_reg.cell_index) * LIST_AW'(CELL_CAPACITY)
                        + LIST_AW'(cnt_rdata[SLOT_W-1:0]);

    always_comb
    begin
        if (state_reg == S_CLEAR)
        begin
            cnt_we    = 1'b1;
            cnt_waddr = clr_reg;
            cnt_wdata = '0;
        end
        else
        begin
            cnt_we    = (state_reg == S_READ);
            cnt_waddr = cur_reg.cell_index;
            cnt_wdata = cnt_now;
        end
    end

    vgpb_ram #(.WIDTH(CNT_W), .DEPTH(GRID_CELLS)) u_counts (
        .clk     (clk),
        .wr_en   (cnt_we),
        .wr_addr (cnt_waddr),
        .wr_data (cnt_wdata),
        .rd_en   (take),
        .rd_addr (item.cell_index),
        .rd_data (cnt_rdata)
    );

    vgpb_ram #(.WIDTH(PNUM_W), .DEPTH(LIST_DEPTH)) u_lists (
        .clk     (clk),
        .wr_en   ((state_reg == S_READ) && keep),
        .wr_addr (list_addr),
        .wr_data (cur_reg.point_number),
        .rd_en   (1'b0),
        .rd_addr ('0),
        .rd_data ()
    );

    assign out_valid  = (state_reg == S_OUT);
    assign cell_index = idx_out_reg;
    assign slot       = slot_reg;
    assign stored     = stored_reg;
    assign overflow   = ovf_reg;
    assign clamped    = clamp_reg;
    assign clearing   = (state_reg == S_CLEAR);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
        end
        else
        begin
            case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == IDX_W'(GRID_CELLS - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (item_valid)
                    begin
                        state_reg <= S_READ;
                    end
                end
                S_READ: state_reg <= S_OUT;
                S_OUT:
                begin
                    if (out_ready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            cur_reg <= item;
        end
        if (state_reg == S_READ)
        begin
            idx_out_reg <= cur_reg.cell_index;
            slot_reg    <= cnt_rdata;
            stored_reg  <= keep;
            ovf_reg     <= {1'b0, cnt_now} > CAP;
            clamp_reg   <= cur_reg.clamped;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ) |=> out_valid)
        else $error("back: result not presented after counter update");
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (stored == (slot < CNT_W'(CELL_CAPACITY))))
        else $error("back: stored flag disagrees with slot");
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && stored) |-> !overflow)
        else $error("back: stored point reported as overflow");
endmodule

// ===== design/voxel_grid_point_binner.sv =====
// Top level of the voxel grid point binner: registers, front, queue and back parts.
// Path: the front's bit-serial division steps and its clamp and index step, then the
// two-entry queue, then the counter RAM read and update and the result register in the back.
// The front takes no new point until its divider result is handed to the queue; a stalled
// result fills the two-entry queue before it holds up the front.
// Reset: asynchronous, active low; registers take their reset values and the
// back part sweeps the 512-entry counter RAM to zero, during which no input
// transaction is accepted. Configuration writes are always taken.
module voxel_grid_point_binner #(
    parameter int CELL_CAPACITY = 1024
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [vgpb_pkg::COORD_W-1:0] coord_x,
    input  logic signed [vgpb_pkg::COORD_W-1:0] coord_y,
    input  logic signed [vgpb_pkg::COORD_W-1:0] coord_z,
    input  logic [vgpb_pkg::PNUM_W-1:0]         point_number,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [vgpb_pkg::IDX_W-1:0]          cell_index,
    output logic [vgpb_pkg::CNT_W-1:0]          slot,
    output logic                                stored,
    output logic                                overflow,
    output logic                                clamped,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [vgpb_pkg::REG_IDX_W-1:0]      cfg_index,
    input  logic [vgpb_pkg::COORD_W-1:0]        cfg_data
);
    import vgpb_pkg::*;

    // Configuration registers. Writes beyond the register list are dropped.
    logic signed [COORD_W-1:0] min_x_reg, min_y_reg, min_z_reg;
    logic [DIV_W-1:0]          div_x_reg, div_y_reg, div_z_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_x_reg <= '0;
            min_y_reg <= '0;
            min_z_reg <= '0;
            div_x_reg <= DIV_W'(65536);
            div_y_reg <= DIV_W'(65536);
            div_z_reg <= DIV_W'(65536);
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_MIN_X: min_x_reg <= cfg_data;
                REG_MIN_Y: min_y_reg <= cfg_data;
                REG_MIN_Z: min_z_reg <= cfg_data;
                REG_DIV_X: div_x_reg <= cfg_data[DIV_W-1:0];
                REG_DIV_Y: div_y_reg <= cfg_data[DIV_W-1:0];
                REG_DIV_Z: div_z_reg <= cfg_data[DIV_W-1:0];
                default: ;
            endcase
        end
    end

    // The front is held off while the back clears its counters, so no point
    // can be classified before its counter is known to be zero.
    logic       clearing;
    logic       front_in_ready;
    logic       f_valid, f_ready;
    vgpb_item_t f_item;
    logic       q_valid, q_ready;
    vgpb_item_t q_item;

    assign in_ready = front_in_ready && !clearing;

    vgpb_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid && !clearing),
        .in_ready     (front_in_ready),
        .coord_x      (coord_x),
        .coord_y      (coord_y),
        .coord_z      (coord_z),
        .point_number (point_number),
        .min_x        (min_x_reg),
        .min_y        (min_y_reg),
        .min_z        (min_z_reg),
        .div_x        (div_x_reg),
        .div_y        (div_y_reg),
        .div_z        (div_z_reg),
        .item_valid   (f_valid),
        .item_ready   (f_ready),
        .item         (f_item)
    );

    // Short queue so a stalled result does not hold up classification.
    vgpb_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (f_valid),
        .wr_ready (f_ready),
        .wr_item  (f_item),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_item  (q_item)
    );

    vgpb_back #(.CELL_CAPACITY(CELL_CAPACITY)) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (q_valid),
        .item_ready (q_ready),
        .item       (q_item),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .cell_index (cell_index),
        .slot       (slot),
        .stored     (stored),
        .overflow   (overflow),
        .clamped    (clamped),
        .clearing   (clearing)
    );

    assert property (@(posedge clk) disable iff (!rst_n) clearing |-> !in_ready)
        else $error("top: input taken during counter clear");
    assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_valid && cfg_index == REG_DIV_X) |=> div_x_reg == $past(cfg_data[DIV_W-1:0]))
        else $error("top: x divisor write lost");
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (cell_index[2:0] <= 3'd7))
        else $error("top: cell index malformed");
endmodule
